// File: design/xxh_pkg.sv
package xxh_pkg;

    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

    localparam int unsigned NUM_LANES = 4;
    localparam logic [5:0]  STRIPE_BYTES = 6'd32;

    // Rotate left by a constant amount between 1 and 63.
    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned s);
        rotl = (x << s) | (x >> (64 - s));
    endfunction

endpackage

// File: design/xxh_mul.sv
module xxh_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_valid,
    output logic [63:0] o_p
);

    // Low 64 bits of a 64x64 product from three 32x32 partial products.
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic        r_v1;
    logic        r_v2;
    logic [31:0] mid_sum;

    assign ll = 64'(i_a[31:0]) * 64'(i_b[31:0]);
    assign lh = i_a[31:0] * i_b[63:32];
    assign hl = i_a[63:32] * i_b[31:0];
    assign mid_sum = r_lh + r_hl;

    always_ff @(posedge i_clk) begin
        r_ll <= ll;
        r_lh <= lh;
        r_hl <= hl;
        r_p  <= r_ll + {mid_sum, 32'h0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;

endmodule

// File: design/xxh_lane.sv
module xxh_lane (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_acc,
    input  logic [63:0] i_word,
    output logic        o_done,
    output logic [63:0] o_result
);

    // One lane round: rotl(acc + word * P2, 31) * P1, two passes through the multiplier.
    logic        m_go;
    logic        m_vld;
    logic [63:0] m_a;
    logic [63:0] m_b;
    logic [63:0] m_p;
    logic [63:0] r_a;
    logic        r_ph;

    assign m_go = i_start | (m_vld & !r_ph);
    assign m_a  = i_start ? i_word : xxh_pkg::rotl(r_a + m_p, 31);
    assign m_b  = i_start ? xxh_pkg::P2 : xxh_pkg::P1;

    xxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_go),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_valid (m_vld),
        .o_p     (m_p)
    );

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 1'b0;
        end else if (i_start) begin
            r_ph <= 1'b0;
        end else if (m_vld) begin
            r_ph <= !r_ph;
        end
    end

    assign o_done   = m_vld & r_ph;
    assign o_result = m_p;

endmodule

// File: design/xxh64_stripe_hasher.sv
// Non-last stripe: the next word is taken once the round is done (two multiplies
// in every lane, all four lanes in parallel).
// Last stripe: the digest is produced by the lane passes, the serial merge, the tail
// steps and the avalanche; the merge, tail steps and avalanche share one multiplier.
// The digest waits in an output register; input stalls whenever the hasher is not idle.
// Synchronous active-low reset clears control state and the seed register.
module xxh64_stripe_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_word_zero,
    input  logic [63:0] i_word_one,
    input  logic [63:0] i_word_two,
    input  logic [63:0] i_word_three,
    input  logic [5:0]  i_stripe_bytes,
    input  logic        i_last_stripe,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_value,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RND   = 11'b00000000010,
        S_CONV  = 11'b00000000100,
        S_TAILW = 11'b00000001000,
        S_MRG   = 11'b00000010000,
        S_TAIL8 = 11'b00000100000,
        S_TAIL4 = 11'b00001000000,
        S_TAIL1 = 11'b00010000000,
        S_AV1   = 11'b00100000000,
        S_AV2   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state      r_state;
    logic [63:0] r_seed;
    logic [63:0] r_seedm;
    logic [63:0] r_acc [4];
    logic [63:0] r_conv [4];
    logic [63:0] r_tw [4];
    logic [63:0] r_w [4];
    logic [63:0] r_len;
    logic [5:0]  r_tn;
    logic [5:0]  r_pos;
    logic        r_last;
    logic        r_inmsg;
    logic        r_sub;
    logic        r_pend;
    logic [1:0]  r_k;
    logic [63:0] r_h;
    logic        r_ovld;
    logic [63:0] r_out;

    logic        accept;
    logic        out_load;
    logic [5:0]  n_bytes;
    logic        full;
    logic [63:0] seed_use;
    logic [63:0] base [4];
    logic [63:0] in_w [4];
    logic        lane_start;
    logic [63:0] lane_a [4];
    logic [63:0] lane_x [4];
    logic [3:0]  lane_done;
    logic [63:0] lane_res [4];

    logic        mul_go;
    logic        mul_vld;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] mul_p;
    logic        mul_state;
    logic [1:0]  idx;
    logic [63:0] tail_byte;
    logic [63:0] rolsum;

    function automatic t_state tail_next(input logic [5:0] tn, input logic [5:0] pos);
        logic [5:0] rem;
        rem = tn - pos;
        if (rem >= 6'd8) begin
            tail_next = S_TAIL8;
        end else if (rem >= 6'd4) begin
            tail_next = S_TAIL4;
        end else if (rem != 6'd0) begin
            tail_next = S_TAIL1;
        end else begin
            tail_next = S_AV1;
        end
    endfunction

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign n_bytes = (i_last_stripe && i_stripe_bytes <= xxh_pkg::STRIPE_BYTES)
                     ? i_stripe_bytes : xxh_pkg::STRIPE_BYTES;
    assign full    = (n_bytes == xxh_pkg::STRIPE_BYTES);

    // A finished digest moves to the output register once that register is free.
    assign out_load = (r_state == S_OUT) && (!r_ovld || !i_stall);

    // The seed is sampled on the first word of a message.
    assign seed_use = r_inmsg ? r_seedm : r_seed;
    assign base[0]  = r_inmsg ? r_acc[0] : r_seed + xxh_pkg::P1 + xxh_pkg::P2;
    assign base[1]  = r_inmsg ? r_acc[1] : r_seed + xxh_pkg::P2;
    assign base[2]  = r_inmsg ? r_acc[2] : r_seed;
    assign base[3]  = r_inmsg ? r_acc[3] : r_seed - xxh_pkg::P1;

    assign in_w[0] = i_word_zero;
    assign in_w[1] = i_word_one;
    assign in_w[2] = i_word_two;
    assign in_w[3] = i_word_three;

    assign lane_start = (accept && full) ||
                        ((r_state == S_CONV || r_state == S_TAILW) && !r_sub);

    for (genvar g = 0; g < xxh_pkg::NUM_LANES; g++) begin : g_lane
        assign lane_a[g] = (r_state == S_CONV || r_state == S_TAILW) ? 64'h0 : base[g];
        assign lane_x[g] = (r_state == S_CONV)  ? r_acc[g] :
                           (r_state == S_TAILW) ? r_w[g] : in_w[g];

        xxh_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (lane_start),
            .i_acc    (lane_a[g]),
            .i_word   (lane_x[g]),
            .o_done   (lane_done[g]),
            .o_result (lane_res[g])
        );
    end

    assign rolsum = xxh_pkg::rotl(r_acc[0], 1) + xxh_pkg::rotl(r_acc[1], 7) +
                    xxh_pkg::rotl(r_acc[2], 12) + xxh_pkg::rotl(r_acc[3], 18);

    assign idx       = r_pos[4:3];
    assign tail_byte = {56'h0, 8'(r_w[idx] >> {r_pos[2:0], 3'b000})};

    always_comb begin
        mul_state = 1'b1;
        mul_a     = r_h;
        mul_b     = xxh_pkg::P1;
        case (r_state)
            S_MRG: begin
                mul_a = r_h ^ r_conv[r_k];
            end
            S_TAIL8: begin
                mul_a = xxh_pkg::rotl(r_h ^ r_tw[idx], 27);
            end
            S_TAIL4: begin
                mul_a = r_sub ? xxh_pkg::rotl(r_h, 23) : {32'h0, r_w[idx][31:0]};
                mul_b = r_sub ? xxh_pkg::P2 : xxh_pkg::P1;
            end
            S_TAIL1: begin
                mul_a = r_sub ? xxh_pkg::rotl(r_h, 11) : tail_byte;
                mul_b = r_sub ? xxh_pkg::P1 : xxh_pkg::P5;
            end
            S_AV1: begin
                mul_a = r_h ^ (r_h >> 33);
                mul_b = xxh_pkg::P2;
            end
            S_AV2: begin
                mul_a = r_h ^ (r_h >> 29);
                mul_b = xxh_pkg::P3;
            end
            default: begin
                mul_state = 1'b0;
            end
        endcase
    end

    assign mul_go = mul_state && !r_pend;

    xxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_valid (mul_vld),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'h0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (!i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inmsg <= 1'b0;
            r_sub   <= 1'b0;
            r_pend  <= 1'b0;
            r_k     <= 2'd0;
            r_pos   <= 6'd0;
            r_len   <= 64'h0;
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= 64'h0;
            end
        end else begin
            if (mul_go) begin
                r_pend <= 1'b1;
            end else if (mul_vld) begin
                r_pend <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        for (int i = 0; i < 4; i++) begin
                            r_acc[i] <= base[i];
                            r_w[i]   <= in_w[i];
                        end
                        r_seedm <= seed_use;
                        r_len   <= (r_inmsg ? r_len : 64'h0) + 64'(n_bytes);
                        r_tn    <= full ? 6'd0 : n_bytes;
                        r_last  <= i_last_stripe;
                        r_sub   <= 1'b0;
                        r_state <= full ? S_RND : S_CONV;
                    end
                end
                S_RND: begin
                    if (lane_done[0]) begin
                        for (int i = 0; i < 4; i++) begin
                            r_acc[i] <= lane_res[i];
                        end
                        if (r_last) begin
                            r_state <= S_CONV;
                        end else begin
                            r_inmsg <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_CONV: begin
                    r_sub <= 1'b1;
                    if (lane_done[0]) begin
                        for (int i = 0; i < 4; i++) begin
                            r_conv[i] <= lane_res[i];
                        end
                        r_sub   <= 1'b0;
                        r_state <= S_TAILW;
                    end
                end
                S_TAILW: begin
                    r_sub <= 1'b1;
                    if (lane_done[0]) begin
                        for (int i = 0; i < 4; i++) begin
                            r_tw[i] <= lane_res[i];
                        end
                        r_sub <= 1'b0;
                        r_pos <= 6'd0;
                        r_k   <= 2'd0;
                        if (r_len >= 64'd32) begin
                            r_h     <= rolsum;
                            r_state <= S_MRG;
                        end else begin
                            r_h     <= r_seedm + xxh_pkg::P5 + r_len;
                            r_state <= tail_next(r_tn, 6'd0);
                        end
                    end
                end
                S_MRG: begin
                    if (mul_vld) begin
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_h     <= mul_p + xxh_pkg::P4 + r_len;
                            r_state <= tail_next(r_tn, r_pos);
                        end else begin
                            r_h <= mul_p + xxh_pkg::P4;
                        end
                    end
                end
                S_TAIL8: begin
                    if (mul_vld) begin
                        r_h     <= mul_p + xxh_pkg::P4;
                        r_pos   <= r_pos + 6'd8;
                        r_state <= tail_next(r_tn, r_pos + 6'd8);
                    end
                end
                S_TAIL4: begin
                    if (mul_vld) begin
                        if (!r_sub) begin
                            r_h   <= r_h ^ mul_p;
                            r_sub <= 1'b1;
                        end else begin
                            r_h     <= mul_p + xxh_pkg::P3;
                            r_sub   <= 1'b0;
                            r_pos   <= r_pos + 6'd4;
                            r_state <= tail_next(r_tn, r_pos + 6'd4);
                        end
                    end
                end
                S_TAIL1: begin
                    if (mul_vld) begin
                        if (!r_sub) begin
                            r_h   <= r_h ^ mul_p;
                            r_sub <= 1'b1;
                        end else begin
                            r_h     <= mul_p;
                            r_sub   <= 1'b0;
                            r_pos   <= r_pos + 6'd1;
                            r_state <= tail_next(r_tn, r_pos + 6'd1);
                        end
                    end
                end
                S_AV1: begin
                    if (mul_vld) begin
                        r_h     <= mul_p;
                        r_state <= S_AV2;
                    end
                end
                S_AV2: begin
                    if (mul_vld) begin
                        r_h     <= mul_p ^ (mul_p >> 32);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_inmsg <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ovld;
    assign o_hash_value = r_out;

    // All lanes start together and share one latency.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_done[0] |-> (lane_done == 4'hF))
        else $error("lanes finished out of step");

    a_no_mul_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !r_pend)
        else $error("multiply pending outside the finishing sequence");

    a_pos_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL8 || r_state == S_TAIL4 || r_state == S_TAIL1) |-> r_pos < r_tn)
        else $error("tail position past byte count");

    a_round_done_in_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("digest shown without avalanche");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_word_zero;
    logic [63:0] i_word_one;
    logic [63:0] i_word_two;
    logic [63:0] i_word_three;
    logic [5:0]  i_stripe_bytes;
    logic        i_last_stripe;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_hash_value;
    logic        i_cfg_we;
    logic [63:0] i_cfg_wdata;

    xxh64_stripe_hasher dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word_zero(i_word_zero),
        .i_word_one(i_word_one),
        .i_word_two(i_word_two),
        .i_word_three(i_word_three),
        .i_stripe_bytes(i_stripe_bytes),
        .i_last_stripe(i_last_stripe),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_hash_value(o_hash_value),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    typedef struct packed {
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [5:0]  nbytes;
        logic        last;
    } t_stripe;

    typedef struct {
        t_stripe     s;
        logic        known;
        logic [63:0] digest;
    } t_vec;

    // Predictor state.
    logic [63:0] seed_reg;
    logic [63:0] acc [4];
    logic [63:0] msg_len;
    logic        mid_msg;

    logic [63:0] digest_q [$];
    int          n_errors;
    bit          rx_quiet;
    bit          long_hold;

    function automatic logic [63:0] rol64(input logic [63:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] mix_lane(input logic [63:0] a, input logic [63:0] x);
        return rol64(a + x * xxh_pkg::P2, 31) * xxh_pkg::P1;
    endfunction

    // Advances the predictor by one word; returns 1 with a digest on a last word.
    function automatic bit hash_word(input t_stripe s, output logic [63:0] h);
        logic [63:0] w [4];
        int n;
        int pos;
        w[0] = s.w0; w[1] = s.w1; w[2] = s.w2; w[3] = s.w3;
        n = s.nbytes;
        if (n > 32 || !s.last) n = 32;
        if (!mid_msg) begin
            acc[0] = seed_reg + xxh_pkg::P1 + xxh_pkg::P2;
            acc[1] = seed_reg + xxh_pkg::P2;
            acc[2] = seed_reg;
            acc[3] = seed_reg - xxh_pkg::P1;
            msg_len = 0;
        end
        msg_len += n;
        if (n == 32) begin
            for (int k = 0; k < 4; k++) acc[k] = mix_lane(acc[k], w[k]);
        end
        if (!s.last) begin
            mid_msg = 1;
            return 0;
        end
        if (msg_len < 32) begin
            h = seed_reg + xxh_pkg::P5;
        end else begin
            h = rol64(acc[0], 1) + rol64(acc[1], 7) + rol64(acc[2], 12) + rol64(acc[3], 18);
            for (int k = 0; k < 4; k++) begin
                h = ((h ^ mix_lane(64'd0, acc[k])) * xxh_pkg::P1) + xxh_pkg::P4;
            end
        end
        h += msg_len;
        if (n < 32) begin
            pos = 0;
            while (n - pos >= 8) begin
                h ^= mix_lane(64'd0, w[pos >> 3]);
                h = rol64(h, 27) * xxh_pkg::P1 + xxh_pkg::P4;
                pos += 8;
            end
            if (n - pos >= 4) begin
                h ^= {32'd0, w[pos >> 3][31:0]} * xxh_pkg::P1;
                h = rol64(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
                pos += 4;
            end
            while (pos < n) begin
                h ^= {56'd0, w[pos >> 3][(pos % 8) * 8 +: 8]} * xxh_pkg::P5;
                h = rol64(h, 11) * xxh_pkg::P1;
                pos++;
            end
        end
        h ^= h >> 33;
        h *= xxh_pkg::P2;
        h ^= h >> 29;
        h *= xxh_pkg::P3;
        h ^= h >> 32;
        mid_msg = 0;
        return 1;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("testbench failed");
        $finish;
    end

    // Receiver side: random stall bursts, one long hold, and checking.
    initial begin
        int burst;
        int hold;
        i_stall = 1'b0;
        burst = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected word: hash_value 0x%h", o_hash_value);
                    n_errors++;
                end else begin
                    logic [63:0] exp_h;
                    exp_h = digest_q.pop_front();
                    if (exp_h !== o_hash_value) begin
                        $error("hash_value mismatch: expected 0x%h actual 0x%h",
                               exp_h, o_hash_value);
                        n_errors++;
                    end
                end
            end
            if (long_hold) begin
                long_hold = 1'b0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 18);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    bit tx_quiet;

    // Valid stays high after the accepting edge until the next word or a drain.
    task automatic send_word(input t_stripe s);
        logic [63:0] h;
        if (!tx_quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word_zero <= s.w0;
        i_word_one <= s.w1;
        i_word_two <= s.w2;
        i_word_three <= s.w3;
        i_stripe_bytes <= s.nbytes;
        i_last_stripe <= s.last;
        do @(posedge i_clk); while (o_stall);
        if (hash_word(s, h)) digest_q.push_back(h);
    endtask

    // Lets all outstanding digests drain, then the pipeline settle, before a seed write.
    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (digest_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_seed(input logic [63:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seed_reg = v;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            default: return rnd64();
        endcase
    endfunction

    task automatic send_message(input int nfull, input int tail, input bit odd_counts);
        t_stripe s;
        for (int i = 0; i < nfull; i++) begin
            s = {pick64(), pick64(), pick64(), pick64(),
                 odd_counts ? 6'($urandom) : 6'd32, 1'b0};
            send_word(s);
        end
        s = {pick64(), pick64(), pick64(), pick64(), 6'(tail), 1'b1};
        send_word(s);
    endtask

    t_vec dir_tab [$];

    initial begin
        int msgs;
        i_rst_n = 0;
        i_valid = 0;
        i_word_zero = 0;
        i_word_one = 0;
        i_word_two = 0;
        i_word_three = 0;
        i_stripe_bytes = 0;
        i_last_stripe = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        seed_reg = 0;
        msg_len = 0;
        mid_msg = 0;
        for (int k = 0; k < 4; k++) acc[k] = 0;
        n_errors = 0;
        rx_quiet = 0;
        tx_quiet = 0;
        long_hold = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Known digests: the empty message with seed 0, whatever the
        // words carry.
        dir_tab.push_back('{'{0, 0, 0, 0, 6'd0, 1'b1}, 1'b1, 64'hEF46DB3751D8E999});
        dir_tab.push_back('{'{'1, '1, '1, '1, 6'd0, 1'b1}, 1'b1, 64'hEF46DB3751D8E999});
        dir_tab.push_back('{'{'1, '1, '1, '1, 6'd1, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), 0, 0, 6'd3, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), 0, 0, 6'd4, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), 0, 0, 6'd8, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), rnd64(), 0, 6'd13, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), rnd64(), rnd64(), 6'd31, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), rnd64(), rnd64(), 6'd32, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{'1, '1, '1, '1, 6'd63, 1'b1}, 1'b0, 0});
        // Short count on a non-last word counts as a full stripe.
        dir_tab.push_back('{'{rnd64(), rnd64(), rnd64(), rnd64(), 6'd5, 1'b0}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), rnd64(), rnd64(), 6'd0, 1'b1}, 1'b0, 0});
        dir_tab.push_back('{'{'1, '1, '1, '1, 6'd32, 1'b0}, 1'b0, 0});
        dir_tab.push_back('{'{'1, '1, '1, '1, 6'd40, 1'b0}, 1'b0, 0});
        dir_tab.push_back('{'{rnd64(), rnd64(), rnd64(), rnd64(), 6'd27, 1'b1}, 1'b0, 0});
        foreach (dir_tab[i]) begin
            send_word(dir_tab[i].s);
            // A row with a typed digest is checked against that value.
            if (dir_tab[i].known) digest_q[digest_q.size() - 1] = dir_tab[i].digest;
        end

        // Random part across several seeds, the extremes among them.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_seed('1);
                1: set_seed(64'd1);
                2: set_seed(rnd64());
                3: set_seed(64'h8000000000000000);
                default: set_seed(rnd64());
            endcase
            if (ph == 2) long_hold = 1'b1;
            if (ph == 4) begin
                tx_quiet = 1;
                rx_quiet = 1;
            end
            msgs = 0;
            while (msgs < 80) begin
                int nf;
                nf = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
                send_message(nf, $urandom_range(0, 32), $urandom_range(0, 3) == 0);
                msgs++;
                // Seed change in the middle of a message takes effect next message.
                if (ph == 3 && msgs == 50) begin
                    drain();
                    send_word({rnd64(), rnd64(), rnd64(), rnd64(), 6'd32, 1'b0});
                    drain();
                    i_cfg_we <= 1'b1;
                    i_cfg_wdata <= rnd64();
                    @(posedge i_clk);
                    i_cfg_we <= 1'b0;
                    send_word({rnd64(), rnd64(), rnd64(), rnd64(), 6'd9, 1'b1});
                    seed_reg = i_cfg_wdata;
                end
            end
        end

        drain();
        if (n_errors == 0 && digest_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            if (digest_q.size() != 0) $error("%0d digests never arrived", digest_q.size());
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/xxh_pkg.sv
design/xxh_mul.sv
design/xxh_lane.sv
design/xxh64_stripe_hasher.sv
dv/testbench.sv
